// ===== rtl/swdm_pkg.sv =====
// swdm_pkg: shared types, codes and constants of the single-wire debug master
// used by swdm_engine and single_wire_debug_master; no dependencies
`timescale 1ns / 1ps

package swdm_pkg;

    // default widths of the frame fields
    localparam int ADDR_BITS_DEF = 7;
    localparam int DATA_BITS_DEF = 32;

    // tick counter and configuration port widths
    localparam int TICK_W    = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 18;

    // request types
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RST_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RST_LOW  = 3'd6;

    // configuration reset values
    localparam logic [3:0]        RST_ONE_LOW  = 4'd2;
    localparam logic [5:0]        RST_ZERO_LOW = 6'd7;
    localparam logic [5:0]        RST_GAP      = 6'd2;
    localparam logic [3:0]        RST_SAMPLE   = 4'd3;
    localparam logic [9:0]        RST_STOP     = 10'd80;
    localparam logic [TICK_W-1:0] RST_RST_HIGH = 18'd40000;
    localparam logic [TICK_W-1:0] RST_RST_LOW  = 18'd160000;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_BIT_LOW   = 4'd1,
        PH_BIT_GAP   = 4'd2,
        PH_SLOT_LOW  = 4'd3,
        PH_SLOT_PRE  = 4'd4,
        PH_SLOT_WAIT = 4'd5,
        PH_SLOT_REC  = 4'd6,
        PH_STOP      = 4'd7,
        PH_RST_HIGH  = 4'd8,
        PH_RST_LOW   = 4'd9
    } t_phase;

    // timing registers as seen by the sequencer
    typedef struct packed {
        logic [3:0]        one_low;
        logic [5:0]        zero_low;
        logic [5:0]        gap;
        logic [3:0]        sample;
        logic [9:0]        stop;
        logic [TICK_W-1:0] rst_high;
        logic [TICK_W-1:0] rst_low;
    } t_cfg;

    // wire and status part of one result
    typedef struct packed {
        logic drive;
        logic level;
        logic busy;
        logic read_valid;
    } t_wire;

    // a programmed length of zero counts as one tick
    function automatic logic [TICK_W-1:0] fn_min_one(input logic [TICK_W-1:0] x);
        fn_min_one = (x == '0) ? TICK_W'(1) : x;
    endfunction

endpackage

// ===== rtl/swdm_engine.sv =====
// swdm_engine: per-tick sequencer of the single-wire debug master
// depends on swdm_pkg; state advances once per accepted tick
`timescale 1ns / 1ps

module swdm_engine #(
    parameter int ADDR_BITS = swdm_pkg::ADDR_BITS_DEF,
    parameter int DATA_BITS = swdm_pkg::DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  swdm_pkg::t_cfg       i_cfg,
    input  logic                 i_start_req,
    input  logic [1:0]           i_req_type,
    input  logic [ADDR_BITS-1:0] i_reg_addr,
    input  logic [DATA_BITS-1:0] i_write_data,
    input  logic                 i_line_in,
    output swdm_pkg::t_wire      o_wire,
    output logic [DATA_BITS-1:0] o_read_data
);
    import swdm_pkg::*;

    localparam int FRAME_W = ADDR_BITS + DATA_BITS + 2;
    localparam int BC_W    = $clog2(FRAME_W + 1);
    localparam logic [BC_W-1:0] FRAME_WR  = BC_W'(FRAME_W);
    localparam logic [BC_W-1:0] FRAME_RD  = BC_W'(ADDR_BITS + 2);
    localparam logic [BC_W-1:0] SLOTS_CNT = BC_W'(DATA_BITS);

    t_phase               r_phase, n_phase;
    logic [TICK_W-1:0]    r_tick, n_tick;
    logic [BC_W-1:0]      r_bits, n_bits;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic [DATA_BITS-1:0] r_rdata, n_rdata;
    logic [1:0]           r_kind, n_kind;

    logic                 start_ok;
    logic                 is_rst_req;
    t_phase               e_phase;
    logic [TICK_W-1:0]    tick_new;
    logic [BC_W-1:0]      e_bits;
    logic [BC_W-1:0]      bits_inc;
    logic [BC_W-1:0]      frame_len;
    logic [FRAME_W-1:0]   e_frame;
    logic [DATA_BITS-1:0] e_rdata;
    logic [1:0]           e_kind;
    logic [TICK_W-1:0]    len;
    logic                 time_up;

    // request capture: a request only takes effect in idle
    always_comb begin
        start_ok   = i_start_req && (r_phase == PH_IDLE)
                     && (i_req_type inside {REQ_READ, REQ_WRITE, REQ_RESET});
        is_rst_req = (i_req_type == REQ_RESET);
        e_phase    = r_phase;
        e_kind     = r_kind;
        e_bits     = r_bits;
        e_frame    = r_frame;
        e_rdata    = r_rdata;
        tick_new   = r_tick + TICK_W'(1);
        if (start_ok) begin
            e_kind   = i_req_type;
            e_bits   = '0;
            tick_new = TICK_W'(1);
            if (is_rst_req) begin
                e_phase = PH_RST_HIGH;
            end else begin
                e_phase = PH_BIT_LOW;
                e_frame = {1'b1, i_reg_addr, (i_req_type == REQ_WRITE), i_write_data};
                e_rdata = '0;
            end
        end
        bits_inc  = e_bits + BC_W'(1);
        frame_len = (e_kind == REQ_WRITE) ? FRAME_WR : FRAME_RD;
    end

    // length of the current timed phase
    always_comb begin
        case (e_phase)
            PH_BIT_LOW:   len = e_frame[FRAME_W-1] ? TICK_W'(i_cfg.one_low)
                                                   : TICK_W'(i_cfg.zero_low);
            PH_BIT_GAP:   len = TICK_W'(i_cfg.gap);
            PH_SLOT_WAIT: len = TICK_W'(i_cfg.sample);
            PH_STOP:      len = TICK_W'(i_cfg.stop);
            PH_RST_HIGH:  len = i_cfg.rst_high;
            PH_RST_LOW:   len = i_cfg.rst_low;
            default:      len = TICK_W'(1);
        endcase
        time_up = (tick_new >= fn_min_one(len));
    end

    // next state
    always_comb begin
        n_phase = e_phase;
        n_tick  = tick_new;
        n_bits  = e_bits;
        n_frame = e_frame;
        n_rdata = e_rdata;
        n_kind  = e_kind;
        case (e_phase)
            PH_BIT_LOW: begin
                if (time_up) begin
                    n_phase = PH_BIT_GAP;
                    n_tick  = '0;
                end
            end
            PH_BIT_GAP: begin
                if (time_up) begin
                    n_tick  = '0;
                    n_frame = {e_frame[FRAME_W-2:0], 1'b0};
                    if (bits_inc < frame_len) begin
                        n_bits  = bits_inc;
                        n_phase = PH_BIT_LOW;
                    end else begin
                        n_bits  = '0;
                        n_phase = (e_kind == REQ_WRITE) ? PH_STOP : PH_SLOT_LOW;
                    end
                end
            end
            PH_SLOT_LOW: begin
                n_phase = PH_SLOT_PRE;
                n_tick  = '0;
            end
            PH_SLOT_PRE: begin
                n_phase = PH_SLOT_WAIT;
                n_tick  = '0;
            end
            PH_SLOT_WAIT: begin
                if (time_up) begin
                    n_rdata = {e_rdata[DATA_BITS-2:0], i_line_in};
                    n_phase = PH_SLOT_REC;
                    n_tick  = '0;
                end
            end
            PH_SLOT_REC: begin
                // wait for the target to let the wire go high again
                if (i_line_in) begin
                    n_bits  = bits_inc;
                    n_phase = (bits_inc < SLOTS_CNT) ? PH_SLOT_LOW : PH_STOP;
                    n_tick  = '0;
                end
            end
            PH_STOP, PH_RST_LOW: begin
                if (time_up) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            end
            PH_RST_HIGH: begin
                if (time_up) begin
                    n_phase = PH_RST_LOW;
                    n_tick  = '0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase
    end

    // result of this tick
    always_comb begin
        o_wire      = '0;
        o_wire.busy = 1'b1;
        o_read_data = '0;
        case (e_phase)
            PH_BIT_LOW, PH_SLOT_LOW, PH_RST_LOW: begin
                o_wire.drive = 1'b1;
            end
            PH_SLOT_PRE, PH_RST_HIGH: begin
                o_wire.drive = 1'b1;
                o_wire.level = 1'b1;
            end
            PH_STOP: begin
                if (time_up && (e_kind == REQ_READ)) begin
                    o_wire.read_valid = 1'b1;
                    o_read_data       = e_rdata;
                end
            end
            PH_IDLE: begin
                o_wire.busy = 1'b0;
            end
            default: begin
                o_wire.busy = 1'b1;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bits  <= '0;
            r_frame <= '0;
            r_rdata <= '0;
            r_kind  <= REQ_READ;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bits  <= n_bits;
            r_frame <= n_frame;
            r_rdata <= n_rdata;
            r_kind  <= n_kind;
        end
    end

endmodule

// ===== rtl/single_wire_debug_master.sv =====
// single_wire_debug_master: top level with timing registers and result register
// depends on swdm_pkg and swdm_engine
`timescale 1ns / 1ps

// Master for a one-wire debug link. Each request on the input channel is one
// timing tick: it carries an optional read, write or line-reset request and the
// sampled wire level, and produces exactly one result giving how the wire is
// driven in that tick, a busy flag and, on the last stop tick of a read, the
// received word. One tick is taken every clock cycle while the input is not
// stalled; the sequencer's result is held in an output register, so a new
// tick is accepted whenever that register is empty or being taken. The user
// must write timing registers through the plain write port only while no frame
// is in progress, unenforced by the block; a programmed zero counts as one tick.
module single_wire_debug_master #(
    parameter int ADDR_BITS = swdm_pkg::ADDR_BITS_DEF,
    parameter int DATA_BITS = swdm_pkg::DATA_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port
    input  logic                           i_cfg_we,
    input  logic [swdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swdm_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // tick requests
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_start_req,
    input  logic [1:0]                     i_req_type,
    input  logic [ADDR_BITS-1:0]           i_reg_addr,
    input  logic [DATA_BITS-1:0]           i_write_data,
    input  logic                           i_line_in,
    // tick results
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_line_drive,
    output logic                           o_line_level,
    output logic                           o_busy_res,
    output logic                           o_read_valid,
    output logic [DATA_BITS-1:0]           o_read_data
);
    import swdm_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_out_valid;
    t_wire                r_wire;
    logic [DATA_BITS-1:0] r_read_data;

    logic                 step;
    t_wire                eng_wire;
    logic [DATA_BITS-1:0] eng_read_data;

    // a tick is taken when the result register is free or drains this cycle
    assign o_in_stall = r_out_valid & i_out_stall;
    assign step       = i_in_valid & ~o_in_stall;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_low  <= RST_ONE_LOW;
            r_cfg.zero_low <= RST_ZERO_LOW;
            r_cfg.gap      <= RST_GAP;
            r_cfg.sample   <= RST_SAMPLE;
            r_cfg.stop     <= RST_STOP;
            r_cfg.rst_high <= RST_RST_HIGH;
            r_cfg.rst_low  <= RST_RST_LOW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ONE_LOW:  r_cfg.one_low  <= i_cfg_data[3:0];
                CFG_ZERO_LOW: r_cfg.zero_low <= i_cfg_data[5:0];
                CFG_GAP:      r_cfg.gap      <= i_cfg_data[5:0];
                CFG_SAMPLE:   r_cfg.sample   <= i_cfg_data[3:0];
                CFG_STOP:     r_cfg.stop     <= i_cfg_data[9:0];
                CFG_RST_HIGH: r_cfg.rst_high <= i_cfg_data[TICK_W-1:0];
                CFG_RST_LOW:  r_cfg.rst_low  <= i_cfg_data[TICK_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // tick sequencer
    swdm_engine #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_cfg        (r_cfg),
        .i_start_req  (i_start_req),
        .i_req_type   (i_req_type),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_line_in    (i_line_in),
        .o_wire       (eng_wire),
        .o_read_data  (eng_read_data)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_wire      <= eng_wire;
            r_read_data <= eng_read_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_drive = r_wire.drive;
    assign o_line_level = r_wire.level;
    assign o_busy_res   = r_wire.busy;
    assign o_read_valid = r_wire.read_valid;
    assign o_read_data  = r_read_data;

endmodule
